### rtl/assert_macros.svh
// Assertion macros shared by the hash set RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lphs_pkg.sv
// Types and constants of the linear probing hash set.
package lphs_pkg;

    // Fixed field widths
    localparam int TS_W    = 7;   // table size register and live size
    localparam int SLOT_W  = 6;   // reported slot
    localparam int OCC_W   = 7;   // occupancy count
    localparam int STAT_W  = 3;   // status code
    localparam int OUT_DW  = 16;  // status, slot, occupancy packed to bytes
    localparam int LOAD_W  = OCC_W + 4;

    // Load limit 0.7 as an exact integer ratio
    localparam int LOAD_NUM = 10;
    localparam int LOAD_DEN = 7;

    localparam logic [OCC_W-1:0] COUNT_MAX = '1;
    localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(64);

    typedef logic [1:0]        t_mark;
    typedef logic [STAT_W-1:0] t_status;

    // Slot marks
    localparam t_mark MARK_EMPTY = 2'd0;
    localparam t_mark MARK_USED  = 2'd1;
    localparam t_mark MARK_DEAD  = 2'd2;

    // Result status codes
    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_LOAD     = 3'd1;
    localparam t_status ST_DUP      = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_DELETED  = 3'd4;
    localparam t_status ST_MISSING  = 3'd5;

endpackage

### rtl/lphs_mod.sv
// Bit-serial remainder unit: key modulo table size, one key bit per cycle.
module lphs_mod #(
    parameter int KEY_BITS = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [KEY_BITS-1:0]        i_dividend,
    input  logic [lphs_pkg::TS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [lphs_pkg::TS_W-1:0]  o_rem
);
    import lphs_pkg::*;

    localparam int CW = $clog2(KEY_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [KEY_BITS-1:0] r_sh;
    logic [TS_W-1:0]     r_rem;
    logic [TS_W-1:0]     r_div;

    logic [TS_W:0]       w_trial;
    logic [TS_W:0]       w_diff;
    logic [TS_W-1:0]     n_rem;

    // One restoring step: bring in the next key bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_sh[KEY_BITS-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[TS_W-1:0];
        end else begin
            n_rem = w_trial[TS_W-1:0];
        end
    end

    // Control: load on start, count down the key bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(KEY_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift the dividend out, update the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= {r_sh[KEY_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`include "assert_macros.svh"

    `ASSERT_HOLDS(a_rem_in_range, r_done, r_rem < r_div, "remainder not below divisor")
    `ASSERT_NEXT(a_start_busy, i_start, r_busy, "start did not begin the division")
    `ASSERT_HOLDS(a_done_idle, r_done, !r_busy, "done raised while still dividing")

endmodule

### rtl/linear_probe_hash_set_unit.sv
// Top level of the linear probing hash set: sequencer, slot memory and ports.
//
// Open-addressed hash set of keys with linear probing and tombstones. Each
// request on the slave stream (tuser: 1 insert, 0 delete; tdata: key) gives
// one result on the master stream. After reset the block first clears the slot
// memory, one slot per cycle, all CAPACITY slots, with s_axis_tready low; the
// table_size register can be written at any time but should only change while
// the block is idle. One request at a time: the home slot comes from a
// bit-serial remainder unit taking one key bit per cycle, and the probe walk
// then reads one slot per cycle from the slot memory, probing 1 up to
// table_size slots. An insert turned away by the 0.7 load limit skips the
// remainder unit and the probe walk. The next request is taken while a
// result still waits in the output register.
module linear_probe_hash_set_unit #(
    parameter int  CAPACITY = 64,
    parameter int  KEY_BITS = 31,
    localparam int IN_DW    = ((KEY_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Table size register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lphs_pkg::TS_W-1:0]     i_cfg_data,
    // Request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_DW-1:0]              s_axis_tdata,   // key, zero padded
    input  logic                          s_axis_tuser,   // operation
    // Result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lphs_pkg::OUT_DW-1:0]   m_axis_tdata    // status, slot, occupancy
);
    import lphs_pkg::*;

    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW      = AW + TS_W;
    localparam int CAP_CLIP = (CAPACITY > 127) ? 127 : CAPACITY;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_POST  = 3'd4;

    // Slot memory
    t_mark               r_mem_mark [CAPACITY];
    logic [KEY_BITS-1:0] r_mem_key  [CAPACITY];

    logic [2:0]          r_state;
    logic [TS_W-1:0]     r_table_size;
    logic [OCC_W-1:0]    r_count;
    logic [AW-1:0]       r_clr_addr;

    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [TS_W-1:0]     r_size;
    logic [TS_W-1:0]     r_at;
    logic [TS_W-1:0]     r_left;
    logic                r_have_dead;
    logic [TS_W-1:0]     r_dead_at;

    logic                r_rd_vld;
    logic                r_rd_last;
    logic [TS_W-1:0]     r_rd_at;
    t_mark               r_rd_mark;
    logic [KEY_BITS-1:0] r_rd_key;

    t_status             r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_vld;
    logic [OUT_DW-1:0]   r_out_data;

    logic                w_accept;
    logic [TS_W-1:0]     w_live;
    logic                w_load_fail;
    logic [LOAD_W-1:0]   w_load_lhs;
    logic [LOAD_W-1:0]   w_load_rhs;
    logic                w_mod_start;
    logic                w_mod_done;
    logic [TS_W-1:0]     w_home;
    logic                w_out_free;

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [XW-1:0]       w_rd_wide;
    logic [TS_W-1:0]     n_at;

    logic                w_fin;
    t_status             w_fin_status;
    logic [TS_W-1:0]     w_fin_slot;
    logic                w_upd_en;
    t_mark               w_upd_mark;
    logic [KEY_BITS-1:0] w_upd_key;
    logic [TS_W-1:0]     w_upd_at;
    logic [OCC_W-1:0]    n_count;
    logic                n_have_dead;
    logic [TS_W-1:0]     n_dead_at;
    logic                w_key_eq;

    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [XW-1:0]       w_wr_wide;
    t_mark               w_wr_mark;
    logic [KEY_BITS-1:0] w_wr_key;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_vld || m_axis_tready;

    // Clip the table size to 1 .. CAPACITY
    always_comb begin
        if (r_table_size == '0) begin
            w_live = TS_W'(1);
        end else if (r_table_size > TS_W'(CAP_CLIP)) begin
            w_live = TS_W'(CAP_CLIP);
        end else begin
            w_live = r_table_size;
        end
    end

    // Load limit: 10 * (count + 1) > 7 * size
    assign w_load_lhs  = (LOAD_W'(r_count) + LOAD_W'(1)) * LOAD_W'(LOAD_NUM);
    assign w_load_rhs  = LOAD_W'(w_live) * LOAD_W'(LOAD_DEN);
    assign w_load_fail = w_load_lhs > w_load_rhs;
    assign w_mod_start = w_accept && !(s_axis_tuser && w_load_fail);

    lphs_mod #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (s_axis_tdata[KEY_BITS-1:0]),
        .i_divisor  (w_live),
        .o_done     (w_mod_done),
        .o_rem      (w_home)
    );

    // Probe read address and wrap-around step
    assign w_rd_en   = (r_state == S_PROBE) && (r_left != '0) && !w_fin;
    assign w_rd_wide = XW'(r_at);
    assign w_rd_addr = w_rd_wide[AW-1:0];
    assign n_at      = (r_at == r_size - TS_W'(1)) ? '0 : r_at + TS_W'(1);
    assign w_key_eq  = (r_rd_key == r_key);

    // Evaluate the slot read back in the previous cycle
    always_comb begin
        w_fin        = 1'b0;
        w_fin_status = ST_MISSING;
        w_fin_slot   = '0;
        w_upd_en     = 1'b0;
        w_upd_mark   = MARK_USED;
        w_upd_key    = r_key;
        w_upd_at     = r_rd_at;
        n_count      = r_count;
        n_have_dead  = r_have_dead;
        n_dead_at    = r_dead_at;
        if ((r_state == S_PROBE) && r_rd_vld) begin
            if (r_op) begin
                if (r_rd_mark == MARK_DEAD && !r_have_dead) begin
                    n_have_dead = 1'b1;
                    n_dead_at   = r_rd_at;
                end
                priority if (r_rd_mark == MARK_EMPTY) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_INSERTED;
                    w_upd_en     = 1'b1;
                    w_upd_at     = r_have_dead ? r_dead_at : r_rd_at;
                end else if (r_rd_mark == MARK_USED && w_key_eq) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_DUP;
                end else if (r_rd_last) begin
                    w_fin = 1'b1;
                    if (n_have_dead) begin
                        w_fin_status = ST_INSERTED;
                        w_upd_en     = 1'b1;
                        w_upd_at     = n_dead_at;
                    end else begin
                        w_fin_status = ST_FULL;
                    end
                end else begin
                    // Another key or a tombstone: keep walking
                end
                if (w_upd_en) begin
                    w_fin_slot = w_upd_at;
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + OCC_W'(1);
                    end
                end
            end else begin
                priority if (r_rd_mark == MARK_EMPTY) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_MISSING;
                end else if (r_rd_mark == MARK_USED && w_key_eq) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_DELETED;
                    w_fin_slot   = r_rd_at;
                    w_upd_en     = 1'b1;
                    w_upd_mark   = MARK_DEAD;
                    w_upd_key    = '0;
                    if (r_count != '0) begin
                        n_count = r_count - OCC_W'(1);
                    end
                end else if (r_rd_last) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_MISSING;
                end else begin
                    // Another key or a tombstone: keep walking
                end
            end
        end
    end

    // Memory write port: clearing pass or the slot that a request changes
    assign w_wr_en   = (r_state == S_CLEAR) || w_upd_en;
    assign w_wr_wide = XW'(w_upd_at);
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : w_wr_wide[AW-1:0];
    assign w_wr_mark = (r_state == S_CLEAR) ? MARK_EMPTY : w_upd_mark;
    assign w_wr_key  = (r_state == S_CLEAR) ? '0 : w_upd_key;

    // Slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_mark[w_wr_addr] <= w_wr_mark;
            r_mem_key[w_wr_addr]  <= w_wr_key;
        end
        if (w_rd_en) begin
            r_rd_mark <= r_mem_mark[w_rd_addr];
            r_rd_key  <= r_mem_key[w_rd_addr];
        end
    end

    // Table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser && w_load_fail) begin
                            r_res_status <= ST_LOAD;
                            r_res_slot   <= '0;
                            r_state      <= S_POST;
                        end else begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    if (w_mod_done) begin
                        r_at        <= w_home;
                        r_left      <= r_size;
                        r_have_dead <= 1'b0;
                        r_rd_vld    <= 1'b0;
                        r_state     <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // No read is issued in the finishing cycle, so valid drops
                    r_rd_vld    <= w_rd_en;
                    r_have_dead <= n_have_dead;
                    r_dead_at   <= n_dead_at;
                    r_count     <= n_count;
                    if (w_rd_en) begin
                        r_rd_at   <= r_at;
                        r_rd_last <= (r_left == TS_W'(1));
                        r_at      <= n_at;
                        r_left    <= r_left - TS_W'(1);
                    end
                    if (w_fin) begin
                        r_res_status <= w_fin_status;
                        r_res_slot   <= w_fin_slot[SLOT_W-1:0];
                        r_state      <= S_POST;
                    end
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_key  <= s_axis_tdata[KEY_BITS-1:0];
            r_size <= w_live;
        end
    end

    // Output register: load the finished result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_POST) && w_out_free) begin
            r_out_vld  <= 1'b1;
            r_out_data <= {r_count, r_res_slot, r_res_status};
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

`include "assert_macros.svh"

    `ASSERT_HOLDS(a_probe_in_range, r_state == S_PROBE, r_at < r_size,
                  "probe slot beyond table size")
    `ASSERT_HOLDS(a_eval_in_range, (r_state == S_PROBE) && r_rd_vld, r_rd_at < r_size,
                  "evaluated slot beyond table size")
    `ASSERT_HOLDS(a_write_phase, w_wr_en, (r_state == S_CLEAR) || (r_state == S_PROBE),
                  "slot memory written outside clear or probe")
    `ASSERT_HOLDS(a_no_change_slot,
                  (r_state == S_POST) && ((r_res_status == ST_LOAD) ||
                  (r_res_status == ST_DUP) || (r_res_status == ST_FULL) ||
                  (r_res_status == ST_MISSING)),
                  r_res_slot == '0, "unchanged table reported a slot")

endmodule

### dv/linear_probe_hash_set_unit_test.sv
// Self-checking testbench for the linear probing hash set unit.
module linear_probe_hash_set_unit_test;
    import lphs_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     SLOTS         = 64;
    localparam int     KEY_W         = 31;
    localparam int     IDLE_PCT      = 32;
    localparam int     POOL_SIZE     = 24;
    localparam int     SETTLE_CYCLES = 120;
    localparam longint LIMIT_CYCLES  = 1_200_000;

    // Result fields, status in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_hash_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [TS_W-1:0]     i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;   // key, bit 31 zero padding
    logic                s_axis_tuser  = 1'b0; // operation: 1 insert, 0 delete
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   m_axis_tdata;         // status, slot, occupancy

    // Shadow copy of the slot store, count and size register
    t_mark               tbl_mark [SLOTS];
    logic [KEY_W-1:0]    tbl_key  [SLOTS];
    int unsigned         tbl_count;
    logic [TS_W-1:0]     tbl_size_reg;
    t_hash_result        pending_results [$];

    t_hash_result        seen_result;
    t_hash_result        want_result;
    int                  error_count = 0;
    bit                  steady_mode = 1'b0;

    linear_probe_hash_set_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Stall the result stream at random outside the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    // Clamp the size register to the probed range
    function automatic int live_size();
        if (tbl_size_reg == '0) return 1;
        if (tbl_size_reg > SLOTS) return SLOTS;
        return int'(tbl_size_reg);
    endfunction

    // Apply one insert or delete to the shadow table and return its result
    function automatic t_hash_result apply_request(input logic is_insert,
                                                   input logic [KEY_W-1:0] key);
        t_hash_result res;
        int           size;
        int           home;
        int           at;
        int           dead_at;
        int           target;
        int           i;
        bit           have_dead;
        bit           done;
        size      = live_size();
        home      = int'(longint'(key) % size);
        res       = '0;
        have_dead = 1'b0;
        dead_at   = 0;
        target    = -1;
        done      = 1'b0;
        if (is_insert) begin
            if (10 * (tbl_count + 1) > 7 * size) begin
                res.status = ST_LOAD;
            end else begin
                for (i = 0; i < size && !done; i++) begin
                    at = (home + i) % size;
                    if (tbl_mark[at] == MARK_EMPTY) begin
                        target = have_dead ? dead_at : at;
                        done   = 1'b1;
                    end else if (tbl_mark[at] == MARK_USED && tbl_key[at] == key) begin
                        res.status = ST_DUP;
                        done       = 1'b1;
                    end else if (tbl_mark[at] == MARK_DEAD && !have_dead) begin
                        have_dead = 1'b1;
                        dead_at   = at;
                    end
                end
                // No empty slot met: reuse the first tombstone if any
                if (!done && have_dead) target = dead_at;
                if (target >= 0) begin
                    tbl_mark[target] = MARK_USED;
                    tbl_key[target]  = key;
                    if (tbl_count < 127) tbl_count++;
                    res.status = ST_INSERTED;
                    res.slot   = SLOT_W'(target);
                end else if (!done) begin
                    res.status = ST_FULL;
                end
            end
        end else begin
            res.status = ST_MISSING;
            for (i = 0; i < size && !done; i++) begin
                at = (home + i) % size;
                if (tbl_mark[at] == MARK_EMPTY) begin
                    done = 1'b1;
                end else if (tbl_mark[at] == MARK_USED && tbl_key[at] == key) begin
                    tbl_mark[at] = MARK_DEAD;
                    tbl_key[at]  = '0;
                    if (tbl_count > 0) tbl_count--;
                    res.status = ST_DELETED;
                    res.slot   = SLOT_W'(at);
                    done       = 1'b1;
                end
            end
        end
        res.occupancy = OCC_W'(tbl_count);
        return res;
    endfunction

    task automatic log_mismatch(input string what, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %0d at %0t: %s expected %0d got %0d",
                     error_count, $time, what, want, got);
    endtask

    // Compare each result transaction with the oldest pending expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = t_hash_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                log_mismatch("unrequested result, status", -1, int'(seen_result.status));
            end else begin
                want_result = pending_results.pop_front();
                if (seen_result.status != want_result.status)
                    log_mismatch("status", int'(want_result.status),
                                 int'(seen_result.status));
                if (seen_result.slot != want_result.slot)
                    log_mismatch("slot", int'(want_result.slot), int'(seen_result.slot));
                if (seen_result.occupancy != want_result.occupancy)
                    log_mismatch("occupancy", int'(want_result.occupancy),
                                 int'(seen_result.occupancy));
            end
        end
    end

    // Offer one request, sometimes after a random gap; leaves tvalid high on return
    task automatic send_request(input logic is_insert, input logic [KEY_W-1:0] key);
        if (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk);
            while (!steady_mode && $urandom_range(99) < IDLE_PCT);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= is_insert;
        do @(posedge i_clk);
        while (!s_axis_tready);
        pending_results.push_back(apply_request(is_insert, key));
        @(negedge i_clk);
    endtask

    // Hold off requests until every pending result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the size register while the unit is idle
    task automatic set_table_size(input logic [TS_W-1:0] size);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        tbl_size_reg = size;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Fill a small table with tombstones, then reuse one and miss a full walk
    task automatic test_tombstone_wrap();
        set_table_size(TS_W'(3));
        send_request(1'b1, KEY_W'(0));
        send_request(1'b0, KEY_W'(0));
        send_request(1'b1, KEY_W'(1));
        send_request(1'b0, KEY_W'(1));
        send_request(1'b1, KEY_W'(2));
        send_request(1'b0, KEY_W'(2));
        send_request(1'b1, KEY_W'(5));
        send_request(1'b0, KEY_W'(7));
    endtask

    // Size zero acts as one, oversize acts as the full table
    task automatic test_size_clamp();
        set_table_size(TS_W'(0));
        send_request(1'b1, KEY_W'(11));
        send_request(1'b0, KEY_W'(5));
        set_table_size(TS_W'(1));
        send_request(1'b1, KEY_W'(4));
        set_table_size('1);
        send_request(1'b0, KEY_W'(5));
    endtask

    // Collisions, wrap past the last slot, duplicates and tombstone reuse
    task automatic test_probe_chain();
        send_request(1'b1, KEY_W'(0));
        send_request(1'b1, KEY_W'(0));
        send_request(1'b1, KEY_W'(64));
        send_request(1'b1, '1);
        send_request(1'b1, KEY_W'(127));
        send_request(1'b0, KEY_W'(0));
        send_request(1'b0, KEY_W'(0));
        send_request(1'b1, KEY_W'(128));
        send_request(1'b0, KEY_W'(5));
        send_request(1'b0, '1);
    endtask

    // Push the count over the 0.7 limit on a ten-slot table
    task automatic test_load_limit();
        int i;
        set_table_size(TS_W'(10));
        for (i = 0; i < 5; i++) send_request(1'b1, KEY_W'(20 + i * 10));
        send_request(1'b0, KEY_W'(30));
    endtask

    // Phases of mixed traffic over a small key pool, one size per phase
    task automatic test_random_traffic();
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  size;
        int               phase;
        int               n;
        int               k;
        int               live;
        int               phase_items;
        for (phase = 0; phase < 11; phase++) begin
            case (phase)
                0, 5, 10: size = TS_W'(64);
                2:        size = '0;
                3:        size = '1;
                6:        size = TS_W'(2);
                8:        size = TS_W'(1);
                default:  size = TS_W'($urandom_range(63, 3));
            endcase
            set_table_size(size);
            live        = live_size();
            phase_items = (live == 1) ? 30 : 85;
            // Mix of small keys, keys sharing one home slot, and wide keys
            for (k = 0; k < POOL_SIZE; k++) begin
                case (k % 3)
                    0:       key_pool[k] = KEY_W'($urandom_range(255));
                    1:       key_pool[k] = KEY_W'(key_pool[0] + k * live);
                    default: key_pool[k] = KEY_W'($urandom);
                endcase
            end
            steady_mode = (phase == 5);
            for (n = 0; n < phase_items; n++) begin
                if ($urandom_range(99) < 75) key = key_pool[$urandom_range(POOL_SIZE - 1)];
                else key = KEY_W'($urandom);
                send_request($urandom_range(99) < 55, key);
                if (phase == 4 && n == 40) wait_for_results();
            end
            steady_mode = 1'b0;
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            tbl_mark[i] = MARK_EMPTY;
            tbl_key[i]  = '0;
        end
        tbl_count    = 0;
        tbl_size_reg = TS_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_tombstone_wrap();
        test_size_clamp();
        test_probe_chain();
        test_load_limit();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("linear_probe_hash_set_unit_test: clean");
        end else begin
            $display("linear_probe_hash_set_unit_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("linear_probe_hash_set_unit_test: errors");
        $finish;
    end

endmodule

### linear_probe_hash_set_unit.f
+incdir+rtl
rtl/lphs_pkg.sv
rtl/lphs_mod.sv
rtl/linear_probe_hash_set_unit.sv
dv/linear_probe_hash_set_unit_test.sv
